[sv/ils_pkg.sv]
// Package for the indexed list store: field widths, request and status codes,
// and the command and status structs that join the controller and datapath.
// Depends on nothing.
`default_nettype none

package ils_pkg;

  localparam int DEPTH_DEF       = 64;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int OP_W     = 3;
  localparam int INDEX_W  = 6;
  localparam int DATA_W   = 32;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 3;

  // Request codes carried in the op field.
  localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
  localparam logic [OP_W-1:0] OP_POP    = 3'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
  localparam logic [OP_W-1:0] OP_READ   = 3'd3;
  localparam logic [OP_W-1:0] OP_WRITE  = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY        = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DEL_OVERSTEP = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RW_FAIL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL         = 3'd4;

  typedef enum logic {
    RD_SWEEP,
    RD_INDEX
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_SHIFT,
    WR_HEAD,
    WR_INDEX
  } wr_sel_t;

  typedef struct packed {
    logic                load;
    logic                start_up;
    logic                start_dn;
    logic                step;
    logic                dir_up;
    logic                rd_en;
    rd_sel_t             rd_sel;
    logic                wr_en;
    wr_sel_t             wr_sel;
    logic                cnt_inc;
    logic                cnt_dec;
    logic                out_load;
    logic                rd_result;
    logic [STATUS_W-1:0] status;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            empty;
    logic            idx_ok;
    logic            idx_last;
    logic            last_up;
    logic            last_dn;
  } stat_t;

endpackage

`default_nettype wire

[sv/ils_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module ils_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[sv/ils_ctrl.sv]
// Controller state machine for the indexed list store.
// Depends on ils_pkg; drives the datapath through cmd_t and reads stat_t.
`default_nettype none

module ils_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  wire logic           out_stall,
  output ils_pkg::cmd_t       cmd,
  input  wire ils_pkg::stat_t stat
);

  import ils_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE       = 9'b000000001,
    S_EXEC       = 9'b000000010,
    S_PUSH_SHIFT = 9'b000000100,
    S_PUSH_TAIL  = 9'b000001000,
    S_PUSH_HEAD  = 9'b000010000,
    S_DEL_SHIFT  = 9'b000100000,
    S_DEL_TAIL   = 9'b001000000,
    S_DEL_END    = 9'b010000000,
    S_DONE       = 9'b100000000
  } state_t;

  state_t              state, state_next;
  logic [STATUS_W-1:0] st_code, st_code_next;
  logic                have_q, have_q_next;
  logic                out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd          = '0;
    state_next   = state;
    st_code_next = st_code;
    have_q_next  = have_q;
    case (state)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        have_q_next  = 1'b0;
        st_code_next = ST_OK;
        state_next   = S_DONE;
        case (stat.op)
          OP_PUSH: begin
            if (stat.full) begin
              st_code_next = ST_FULL;
            end else if (stat.empty) begin
              state_next = S_PUSH_HEAD;
            end else begin
              cmd.start_up = 1'b1;
              state_next   = S_PUSH_SHIFT;
            end
          end
          OP_POP, OP_DELETE: begin
            if (!stat.idx_ok) begin
              st_code_next = (stat.op == OP_POP) ? ST_EMPTY : ST_DEL_OVERSTEP;
            end else if (stat.idx_last) begin
              state_next = S_DEL_END;
            end else begin
              cmd.start_dn = 1'b1;
              state_next   = S_DEL_SHIFT;
            end
          end
          OP_READ: begin
            if (!stat.idx_ok) begin
              st_code_next = ST_RW_FAIL;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_INDEX;
            end
          end
          OP_WRITE: begin
            if (!stat.idx_ok) begin
              st_code_next = ST_RW_FAIL;
            end else begin
              cmd.wr_en  = 1'b1;
              cmd.wr_sel = WR_INDEX;
            end
          end
          default: begin
            st_code_next = ST_OK;
          end
        endcase
      end
      S_PUSH_SHIFT: begin
        cmd.step    = 1'b1;
        cmd.dir_up  = 1'b1;
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = RD_SWEEP;
        cmd.wr_en   = have_q;
        cmd.wr_sel  = WR_SHIFT;
        have_q_next = 1'b1;
        if (stat.last_up) begin
          state_next = S_PUSH_TAIL;
        end
      end
      S_PUSH_TAIL: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_SHIFT;
        state_next = S_PUSH_HEAD;
      end
      S_PUSH_HEAD: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_HEAD;
        cmd.cnt_inc = 1'b1;
        state_next  = S_DONE;
      end
      S_DEL_SHIFT: begin
        cmd.step    = 1'b1;
        cmd.dir_up  = 1'b0;
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = RD_SWEEP;
        cmd.wr_en   = have_q;
        cmd.wr_sel  = WR_SHIFT;
        have_q_next = 1'b1;
        if (stat.last_dn) begin
          state_next = S_DEL_TAIL;
        end
      end
      S_DEL_TAIL: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_SHIFT;
        cmd.cnt_dec = 1'b1;
        state_next  = S_DONE;
      end
      S_DEL_END: begin
        cmd.cnt_dec = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        cmd.status    = st_code;
        cmd.rd_result = (stat.op == OP_READ) && (st_code == ST_OK);
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      st_code   <= ST_OK;
      have_q    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      st_code <= st_code_next;
      have_q  <= have_q_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[sv/ils_datapath.sv]
// Datapath of the indexed list store: request registers, entry count, sweep
// pointers, the entry RAM and the result registers.
// Depends on ils_pkg and ils_ram.
`default_nettype none

module ils_datapath #(
  parameter int DEPTH       = ils_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = ils_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire ils_pkg::cmd_t                cmd,
  output ils_pkg::stat_t                    stat,
  input  wire logic [ils_pkg::OP_W-1:0]     op,
  input  wire logic [ils_pkg::INDEX_W-1:0]  index,
  input  wire logic [ils_pkg::DATA_W-1:0]   write_value,
  output logic      [ils_pkg::STATUS_W-1:0] status,
  output logic      [ils_pkg::DATA_W-1:0]   read_value,
  output logic      [ils_pkg::COUNT_W-1:0]  entry_count
);

  import ils_pkg::*;

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = ((CW > INDEX_W) ? CW : INDEX_W) + 1;

  logic [OP_W-1:0]        op_r;
  logic [INDEX_W-1:0]     idx_r;
  logic [VALUE_WIDTH-1:0] val_r;
  logic [CW-1:0]          count;
  logic [AW-1:0]          ptr;
  logic [AW-1:0]          wptr;

  logic [63:0]            val_wide;
  logic [63:0]            q_wide;
  logic [CMPW-1:0]        idx_c;
  logic [CMPW-1:0]        cnt_c;
  logic [AW-1:0]          idx_a;
  logic [AW-1:0]          cnt_last;
  logic [AW-1:0]          raddr;
  logic [AW-1:0]          waddr;
  logic [VALUE_WIDTH-1:0] wdata;
  logic [VALUE_WIDTH-1:0] q;

  assign val_wide = 64'(write_value);
  assign q_wide   = 64'(q);
  assign idx_c    = CMPW'(idx_r);
  assign cnt_c    = CMPW'(count);
  assign idx_a    = AW'(idx_r);
  assign cnt_last = AW'(count - CW'(1));

  assign stat.op       = op_r;
  assign stat.full     = (count >= CW'(DEPTH));
  assign stat.empty    = (count == '0);
  assign stat.idx_ok   = (idx_c < cnt_c);
  assign stat.idx_last = ((idx_c + CMPW'(1)) == cnt_c);
  assign stat.last_up  = (ptr == '0);
  assign stat.last_dn  = (ptr == cnt_last);

  assign raddr = (cmd.rd_sel == RD_SWEEP) ? ptr : idx_a;

  always_comb begin
    case (cmd.wr_sel)
      WR_SHIFT: waddr = wptr;
      WR_HEAD:  waddr = '0;
      WR_INDEX: waddr = idx_a;
      default:  waddr = wptr;
    endcase
    wdata = (cmd.wr_sel == WR_SHIFT) ? q : val_r;
  end

  ils_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (q)
  );

  // A pop is a delete at the front, so its position is stored as zero.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= op;
      idx_r <= (op == OP_POP) ? '0 : index;
      val_r <= val_wide[VALUE_WIDTH-1:0];
    end
    if (cmd.start_up) begin
      ptr <= AW'(count - CW'(1));
    end else if (cmd.start_dn) begin
      ptr <= idx_a + AW'(1);
    end else if (cmd.step) begin
      ptr  <= cmd.dir_up ? (ptr - AW'(1)) : (ptr + AW'(1));
      wptr <= cmd.dir_up ? (ptr + AW'(1)) : (ptr - AW'(1));
    end
    if (cmd.out_load) begin
      status      <= cmd.status;
      read_value  <= cmd.rd_result ? q_wide[DATA_W-1:0] : '0;
      entry_count <= COUNT_W'(count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.cnt_inc) begin
      count <= count + CW'(1);
    end else if (cmd.cnt_dec) begin
      count <= count - CW'(1);
    end
  end

endmodule

`default_nettype wire

[sv/indexed_list_store_unit.sv]
// Top level of the indexed list store: a bounded ordered list held in a RAM.
// Depends on ils_pkg, ils_ctrl, ils_datapath and, through it, ils_ram.
`default_nettype none

// Channel   Direction  Handshake            Payload
// request   in         in_valid / in_stall  op, index, write_value
// result    out        out_valid / out_stall status, read_value, entry_count
//
// A request that moves no entries passes through accept, decide and deliver. A
// push onto a non-empty list adds an upward shifting sweep, a tail write and a
// head write (just the head write onto an empty list); a delete or pop adds a
// downward sweep and a tail write (just a count update at the tail). The single
// RAM write port moves one entry per cycle. Reset clears the entry count and all
// control state; entries hold no reset value. The next request is taken while
// the previous result still waits, and a stalled result only delays delivery.

module indexed_list_store_unit #(
  parameter int DEPTH       = ils_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = ils_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [ils_pkg::OP_W-1:0]     op,
  input  wire logic [ils_pkg::INDEX_W-1:0]  index,
  input  wire logic [ils_pkg::DATA_W-1:0]   write_value,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [ils_pkg::STATUS_W-1:0] status,
  output logic      [ils_pkg::DATA_W-1:0]   read_value,
  output logic      [ils_pkg::COUNT_W-1:0]  entry_count
);

  import ils_pkg::*;

  // Commands flow from the controller; flags about the count, the index and
  // the sweep pointer flow back.
  cmd_t  cmd;
  stat_t stat;

  ils_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  // The datapath stores the request, runs the shifting sweeps in the RAM and
  // holds the result registers that the result channel transfers from.
  ils_datapath #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .op          (op),
    .index       (index),
    .write_value (write_value),
    .status      (status),
    .read_value  (read_value),
    .entry_count (entry_count)
  );

endmodule

`default_nettype wire

[bench/ils_result_checker.sv]
`timescale 1ns / 1ps
// Result checker for the indexed list store: keeps its own copy of the list, predicts
// one result per accepted request and compares each result transfer as it leaves.
// Depends on ils_pkg for the field widths, request codes and status codes.

module ils_result_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [ils_pkg::OP_W-1:0]       op,
  input  logic [ils_pkg::INDEX_W-1:0]    index,
  input  logic [ils_pkg::DATA_W-1:0]     write_value,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [ils_pkg::STATUS_W-1:0]   status,
  input  logic [ils_pkg::DATA_W-1:0]     read_value,
  input  logic [ils_pkg::COUNT_W-1:0]    entry_count,
  output int                             mismatches,
  output int                             outstanding,
  output int                             results_checked,
  output int                             full_refusals
);

  import ils_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   read_value;
    logic [COUNT_W-1:0]  entry_count;
  } list_result_t;

  logic [DATA_W-1:0] list_values [DEPTH_DEF];
  int                list_len;
  list_result_t      owed_results[$];
  int                fail_count;
  int                checked_count;
  int                refusal_count;

  // Applies one request to the mirrored list and returns the result it must give.
  function automatic list_result_t apply_request(input logic [OP_W-1:0]    code,
                                                 input logic [INDEX_W-1:0] pos,
                                                 input logic [DATA_W-1:0]  value);
    list_result_t res;
    int           at;
    res.status     = ST_OK;
    res.read_value = '0;
    case (code)
      OP_PUSH: begin
        if (list_len >= DEPTH_DEF) begin
          res.status = ST_FULL;
        end else begin
          for (int i = list_len; i > 0; i--) list_values[i] = list_values[i-1];
          list_values[0] = value;
          list_len++;
        end
      end
      OP_POP, OP_DELETE: begin
        // A pop is a delete at the front; only the fault code differs.
        at = (code == OP_POP) ? 0 : int'(pos);
        if (at >= list_len) begin
          res.status = (code == OP_POP) ? ST_EMPTY : ST_DEL_OVERSTEP;
        end else begin
          for (int i = at; i + 1 < list_len; i++) list_values[i] = list_values[i+1];
          list_len--;
        end
      end
      OP_READ: begin
        if (int'(pos) >= list_len) res.status = ST_RW_FAIL;
        else res.read_value = list_values[pos];
      end
      OP_WRITE: begin
        if (int'(pos) >= list_len) res.status = ST_RW_FAIL;
        else list_values[pos] = value;
      end
      default: begin
      end
    endcase
    res.entry_count = COUNT_W'(list_len);
    return res;
  endfunction

  always @(posedge clk) begin : watch
    list_result_t want;
    if (rst) begin
      list_len = 0;
      owed_results.delete();
    end else begin
      if (in_valid && !in_stall) owed_results.push_back(apply_request(op, index, write_value));
      if (out_valid && !out_stall) begin
        checked_count++;
        if (owed_results.size() == 0) begin
          $error("result transfer with no request outstanding: status %0d, read_value %h, %s %0d",
                 status, read_value, "entry_count", entry_count);
          fail_count++;
        end else begin
          want = owed_results.pop_front();
          if (want.status == ST_FULL) refusal_count++;
          if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            fail_count++;
          end
          if (read_value !== want.read_value) begin
            $error("read_value: expected %h, actual %h", want.read_value, read_value);
            fail_count++;
          end
          if (entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, actual %0d", want.entry_count, entry_count);
            fail_count++;
          end
        end
      end
    end
    mismatches      <= fail_count;
    outstanding     <= owed_results.size();
    results_checked <= checked_count;
    full_refusals   <= refusal_count;
  end

endmodule

[bench/tb_indexed_list_store_unit.sv]
`timescale 1ns / 1ps
// Testbench top for the indexed list store: drives requests, stalls results and gives the
// verdict. Depends on ils_pkg, the indexed_list_store_unit RTL and ils_result_checker.

module tb_indexed_list_store_unit;

  import ils_pkg::*;

  // Op codes five to seven have no function; the block must answer them with an ok
  // status and leave the list untouched.
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  localparam int RANDOM_PER_PHASE = 250;  // random requests in each idle pattern
  localparam int STRETCH          = 120;  // requests before the random mix flips direction
  localparam int HOLD_LEN         = 300;  // cycles of the one long result hold
  localparam int QUIET_LIMIT      = 4000; // cycles with no transfer before giving up
  localparam int DRAIN_CYCLES     = 100;  // settle time after the last expected result

  logic                clk         = 1'b0;
  logic                rst         = 1'b1;
  logic                in_valid    = 1'b0;
  logic                in_stall;
  logic [OP_W-1:0]     op          = OP_PUSH;
  logic [INDEX_W-1:0]  index       = '0;
  logic [DATA_W-1:0]   write_value = '0;
  logic                out_valid;
  logic                out_stall   = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [DATA_W-1:0]   read_value;
  logic [COUNT_W-1:0]  entry_count;

  int mismatches;
  int outstanding;
  int results_checked;
  int full_refusals;

  // Idle pattern knobs. The stimulus process owns them; the stall process only reads.
  int send_gap_pct   = 27;
  int recv_stall_pct = 74;
  int idle_phase     = 0;
  int requests_sent  = 0;

  // Rough occupancy as seen by the sender. It only steers the random indexes toward valid
  // positions and just past the end; the checker does all of the real prediction.
  int list_fill = 0;

  int  hold_left = 0;
  bit  hold_done = 1'b0;

  indexed_list_store_unit dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .index       (index),
    .write_value (write_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .read_value  (read_value),
    .entry_count (entry_count)
  );

  ils_result_checker result_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .op              (op),
    .index           (index),
    .write_value     (write_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .read_value      (read_value),
    .entry_count     (entry_count),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .full_refusals   (full_refusals)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side. Normally the stall is a coin toss at the current idle pattern. Once the
  // last pattern (no idling) begins, the receiver holds off for a long stretch while the
  // sender keeps offering requests, so the block backs up and must stall its input.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && idle_phase == 2) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_LEN - 1;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Watchdog: a run that goes this long without any transfer on either channel is hung.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Offers one request, after a random idle gap, and returns at the edge of its transfer.
  // The payload stays put while the block stalls it.
  task automatic send_request(input logic [OP_W-1:0]    code,
                              input logic [INDEX_W-1:0] pos,
                              input logic [DATA_W-1:0]  value);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    op          <= code;
    index       <= pos;
    write_value <= value;
    do @(posedge clk); while (in_stall);
    requests_sent++;
    case (code)
      OP_PUSH:   if (list_fill < DEPTH_DEF) list_fill++;
      OP_POP:    if (list_fill > 0) list_fill--;
      OP_DELETE: if (int'(pos) < list_fill) list_fill--;
      default: begin
      end
    endcase
  endtask

  initial begin : stimulus
    int                 pick;
    int                 push_cut;
    int                 pop_cut;
    int                 mixed;
    logic [OP_W-1:0]    code;
    logic [INDEX_W-1:0] pos;
    logic [DATA_W-1:0]  value;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part: every fault on an empty list, the spare op codes, value extremes,
    // reads at both ends and just past the end, writes at the tail and just past the end,
    // and deletes at the middle, the tail and past the tail.
    send_request(OP_POP,    '0, '0);
    send_request(OP_DELETE, '0, '0);
    send_request(OP_READ,   '0, '0);
    send_request(OP_WRITE,  '1, '1);
    for (int c = OP_SPARE_LO; c <= OP_SPARE_HI; c++) send_request(OP_W'(c), '1, '1);
    send_request(OP_PUSH,   '0, '0);
    send_request(OP_PUSH,   '0, '1);
    send_request(OP_PUSH,   '1, 32'hA5A5_5A5A);
    send_request(OP_PUSH,   '0, 32'h0000_0001);
    send_request(OP_READ,   6'd0, '0);
    send_request(OP_READ,   6'd3, '0);
    send_request(OP_READ,   6'd4, '0);
    send_request(OP_WRITE,  6'd3, 32'h8000_0001);
    send_request(OP_READ,   6'd3, '0);
    send_request(OP_WRITE,  6'd4, '1);
    send_request(OP_READ,   '1, '0);
    send_request(OP_DELETE, 6'd1, '0);
    send_request(OP_DELETE, 6'd3, '0);
    send_request(OP_DELETE, 6'd2, '0);
    send_request(OP_READ,   6'd1, '0);
    send_request(OP_POP,    '0, '0);
    send_request(OP_POP,    '0, '0);
    send_request(OP_POP,    '0, '0);

    // Random part in three idle patterns. The mix alternates between stretches that
    // mostly push, which run the list into full, and stretches that mostly pop and delete,
    // which run it back to empty. Indexes mostly land inside the list, sometimes just past
    // its end and sometimes anywhere.
    mixed = 0;
    for (int phase = 0; phase < 3; phase++) begin
      idle_phase     = phase;
      send_gap_pct   = (phase == 0) ? 27 : (phase == 1) ? 74 : 0;
      recv_stall_pct = (phase == 0) ? 74 : (phase == 1) ? 27 : 0;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        push_cut = ((mixed / STRETCH) % 2 == 0) ? 70 : 10;
        pop_cut  = ((mixed / STRETCH) % 2 == 0) ? 75 : 45;
        mixed++;

        pick = $urandom_range(0, 99);
        if (pick < push_cut)    code = OP_PUSH;
        else if (pick < pop_cut) code = OP_POP;
        else if (pick < 80)     code = OP_DELETE;
        else if (pick < 90)     code = OP_READ;
        else if (pick < 98)     code = OP_WRITE;
        else                    code = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));

        pick = $urandom_range(0, 7);
        if (list_fill > 0 && pick < 5) pos = INDEX_W'($urandom_range(0, list_fill - 1));
        else if (pick == 5)            pos = INDEX_W'(list_fill);
        else                           pos = INDEX_W'($urandom_range(0, 63));

        pick = $urandom_range(0, 9);
        if (pick == 0)      value = '0;
        else if (pick == 1) value = '1;
        else                value = $urandom;

        send_request(code, pos, value);
      end
    end
    in_valid <= 1'b0;

    // Let every owed result come out, then give the block time to show any extra one.
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d requests and %0d results, with %0d pushes refused on a full list.",
             requests_sent, results_checked, full_refusals);
    $display("Idle patterns: sender-light, sender-heavy, none; one %0d-cycle result hold.",
             HOLD_LEN);
    if (mismatches == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/ils_pkg.sv
sv/ils_ram.sv
sv/ils_ctrl.sv
sv/ils_datapath.sv
sv/indexed_list_store_unit.sv
bench/ils_result_checker.sv
bench/tb_indexed_list_store_unit.sv
